// File: design/buffer_frame_manager_defines.svh
// assertion macros for the buffer frame manager
`ifndef BUFFER_FRAME_MANAGER_DEFINES_SVH
`define BUFFER_FRAME_MANAGER_DEFINES_SVH
// property that holds outside reset
`define BFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked also during reset
`define BFM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: design/bfm_pkg.sv
// package of types and constants for the buffer frame manager
`default_nettype none
package bfm_pkg;
  localparam int NumFramesDefault = 32;
  localparam int PinBitsDefault = 8;
  localparam int FileW = 8;
  localparam int PageW = 31;
  localparam int FrameW = 5;

  typedef enum logic [2:0] {
    CMD_READ = 3'd0, CMD_ALLOC = 3'd1, CMD_UNPIN = 3'd2, CMD_DISPOSE = 3'd3,
    CMD_FLUSH = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ALL_PINNED = 3'd1, ST_NOT_FOUND = 3'd2, ST_NOT_PINNED = 3'd3,
    ST_PINNED = 3'd4, ST_BAD_FRAME = 3'd5, ST_PIN_LIMIT = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN, S_DECIDE, S_LINK1, S_LINK2, S_LINK3, S_FLUSH_RD,
    S_FLUSH_CHK, S_DONE
  } state_t;
endpackage
`default_nettype wire

// File: design/buffer_frame_manager.sv
// top level of the buffer frame manager
`default_nettype none
// One request is taken when start is high and busy low; busy falls in the cycle that shows
// the last result. Frame state sits in a frame memory with separate read and write ports
// and a link memory, both with registered reads. Lookup sweeps the frame memory one entry
// a cycle; flush reads and then checks each entry in turn. After reset a clearing pass
// clears the frame memory and builds the free list with busy high.
// Results show for one cycle on done with last marking the final one; there is no stall.
module buffer_frame_manager #(
  parameter int NUM_FRAMES = bfm_pkg::NumFramesDefault,
  parameter int PIN_BITS = bfm_pkg::PinBitsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [2:0] command,
  input  wire logic [bfm_pkg::FileW-1:0] file_id,
  input  wire logic [bfm_pkg::PageW-1:0] page_number,
  input  wire logic dirty,
  input  wire logic keep_recent,
  output logic done,
  output logic [2:0] status,
  output logic [bfm_pkg::FrameW-1:0] frame,
  output logic hit,
  output logic need_fill,
  output logic writeback,
  output logic [bfm_pkg::FileW-1:0] writeback_file,
  output logic [bfm_pkg::PageW-1:0] writeback_page,
  output logic last
);
  import bfm_pkg::*;
  localparam int IW = $clog2(NUM_FRAMES + 1);
  localparam logic [IW-1:0] SENT = IW'(NUM_FRAMES);
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  typedef struct packed {
    logic valid;
    logic dirty;
    logic [PIN_BITS-1:0] pins;
    logic [FileW-1:0] file;
    logic [PageW-1:0] page;
  } entry_t;

  entry_t fmem [NUM_FRAMES];
  logic [2*IW-1:0] lmem [NUM_FRAMES+1];

  state_t state, state_next;
  logic [2:0] cmd;
  logic [FileW-1:0] rfile;
  logic [PageW-1:0] rpage;
  logic rdirty, rkeep;
  logic [IW-1:0] idx, tgt, oldest;
  logic found;
  entry_t fent, tent;
  logic [2*IW-1:0] lrd;
  logic [1:0] lstep;

  logic fwe; logic [IW-1:0] fwa; entry_t fwd; logic [IW-1:0] fra;
  logic lwe; logic [IW-1:0] lwa; logic [2*IW-1:0] lwd; logic [IW-1:0] lra;

  always_ff @(posedge clk) begin
    if (fwe) fmem[fwa[$clog2(NUM_FRAMES)-1:0]] <= fwd;
    fent <= fmem[fra[$clog2(NUM_FRAMES)-1:0]];
    if (lwe) lmem[lwa] <= lwd;
    lrd <= lmem[lra];
  end

  // result register
  logic o_done, o_last, o_hit, o_fill, o_wb;
  logic [2:0] o_st; logic [IW-1:0] o_fr;
  logic [FileW-1:0] o_wf; logic [PageW-1:0] o_wp;
  logic [IW-1:0] n_sel, p_sel;
  logic [1:0] linkop; // 0 unlink, 1 front, 2 rear
  logic [IW-1:0] lnk_a, lnk_b;
  logic [IW-1:0] oldest_next;
  logic [IW-1:0] idx_next, tgt_next;
  logic found_next;
  logic [1:0] lstep_next, linkop_next;
  entry_t tent_next;
  logic [IW-1:0] lnk_a_next, lnk_b_next;

  assign busy = (state != S_IDLE);
  assign done = o_done; assign last = o_last; assign status = o_st;
  assign frame = FrameW'(o_fr); assign hit = o_hit; assign need_fill = o_fill;
  assign writeback = o_wb; assign writeback_file = o_wf; assign writeback_page = o_wp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; idx <= '0; oldest <= '0;
    end else begin
      state <= state_next; idx <= idx_next; oldest <= oldest_next;
    end
    tgt <= tgt_next; found <= found_next; lstep <= lstep_next; linkop <= linkop_next;
    tent <= tent_next; lnk_a <= lnk_a_next; lnk_b <= lnk_b_next;
    if (start && !busy) begin
      cmd <= command; rfile <= file_id; rpage <= page_number;
      rdirty <= dirty; rkeep <= keep_recent;
    end
  end

  logic r_done, r_last, r_hit, r_fill, r_wb;
  logic [2:0] r_st; logic [IW-1:0] r_fr;
  always_ff @(posedge clk) begin
    if (rst) o_done <= 1'b0; else o_done <= r_done;
    o_last <= r_last; o_st <= r_st; o_fr <= r_fr; o_hit <= r_hit;
    o_fill <= r_fill; o_wb <= r_wb;
    o_wf <= r_wb ? tent_next.file : '0; o_wp <= r_wb ? tent_next.page : '0;
  end

  assign n_sel = lrd[2*IW-1:IW];
  assign p_sel = lrd[IW-1:0];

  always_comb begin
    state_next = state; idx_next = idx; tgt_next = tgt; found_next = found;
    lstep_next = lstep; linkop_next = linkop; tent_next = tent;
    lnk_a_next = lnk_a; lnk_b_next = lnk_b; oldest_next = oldest;
    fwe = 1'b0; fwa = tgt; fwd = tent; fra = idx;
    lwe = 1'b0; lwa = '0; lwd = '0; lra = tgt;
    r_done = 1'b0; r_last = 1'b1; r_hit = 1'b0; r_fill = 1'b0; r_wb = 1'b0;
    r_st = ST_OK; r_fr = '0;
    unique case (state)
      S_INIT: begin
        lwe = 1'b1; lwa = idx;
        lwd = {(idx == SENT) ? IW'(0) : IW'(idx + 1'b1),
               (idx == '0) ? SENT : IW'(idx - 1'b1)};
        fwe = (idx != SENT); fwa = idx; fwd = '0;
        idx_next = IW'(idx + 1'b1);
        if (idx == SENT) begin
          state_next = S_IDLE; idx_next = '0;
        end
      end
      S_IDLE: begin
        idx_next = '0; found_next = 1'b0; fra = '0;
        if (start) begin
          if (command == CMD_FLUSH) state_next = S_FLUSH_RD;
          else if (command <= CMD_DISPOSE) state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // entry idx is issued, entry idx-1 arrives
        fra = idx;
        if (idx != '0 && !found && fent.valid && fent.file == rfile && fent.page == rpage) begin
          found_next = 1'b1; tgt_next = IW'(idx - 1'b1); tent_next = fent;
        end
        idx_next = IW'(idx + 1'b1);
        if (idx == SENT) state_next = S_DECIDE;
        if (idx == SENT && !found_next) begin
          tgt_next = oldest;
        end
      end
      S_DECIDE: begin
        // for a miss tent holds nothing yet; fetch victim
        fra = tgt; lra = tgt; lstep_next = 2'd0;
        state_next = S_LINK1;
        unique case (cmd)
          CMD_READ, CMD_ALLOC: begin
            if (found) begin
              if (cmd == CMD_ALLOC) begin
                r_done = 1'b1; r_st = ST_BAD_FRAME; r_fr = tgt; state_next = S_IDLE;
              end else if (tent.pins == PIN_MAX) begin
                r_done = 1'b1; r_st = ST_PIN_LIMIT; r_fr = tgt; r_hit = 1'b1;
                state_next = S_IDLE;
              end else begin
                tent_next.pins = tent.pins + 1'b1;
                linkop_next = 2'd0;
                if (tent.pins != '0) begin
                  fwe = 1'b1; fwd = tent_next;
                  r_done = 1'b1; r_fr = tgt; r_hit = 1'b1; state_next = S_IDLE;
                end
              end
            end else if (oldest == SENT) begin
              r_done = 1'b1; r_st = ST_ALL_PINNED; state_next = S_IDLE;
            end else begin
              linkop_next = 2'd0; lstep_next = 2'd3;
            end
          end
          CMD_UNPIN: begin
            if (!found) begin
              r_done = 1'b1; r_st = ST_NOT_FOUND; state_next = S_IDLE;
            end else if (tent.pins == '0) begin
              r_done = 1'b1; r_st = ST_NOT_PINNED; r_fr = tgt; state_next = S_IDLE;
            end else begin
              tent_next.pins = tent.pins - 1'b1;
              tent_next.dirty = tent.dirty | rdirty;
              fwe = 1'b1; fwd = tent_next;
              if (tent.pins != PIN_BITS'(1)) begin
                r_done = 1'b1; r_fr = tgt; state_next = S_IDLE;
              end else begin
                linkop_next = rkeep ? 2'd1 : 2'd2;
                lra = rkeep ? SENT : oldest;
                lnk_a_next = rkeep ? SENT : oldest;
              end
            end
          end
          default: begin
            if (!found) begin
              r_done = 1'b1; r_st = ST_NOT_FOUND; state_next = S_IDLE;
            end else if (tent.pins != '0) begin
              r_done = 1'b1; r_st = ST_PINNED; r_fr = tgt; state_next = S_IDLE;
            end else begin
              fwe = 1'b1; fwd = '0; fwd.file = tent.file; fwd.page = tent.page;
              r_done = 1'b1; r_fr = tgt; state_next = S_IDLE;
            end
          end
        endcase
      end
      S_LINK1: begin
        // lrd holds links of the frame read in S_DECIDE (or of the anchor for linking)
        if (linkop == 2'd0) begin
          if (lstep == 2'd3) tent_next = fent;
          lnk_a_next = p_sel; lnk_b_next = n_sel;
          if (oldest == tgt) oldest_next = n_sel;
          lwe = 1'b1; lwa = p_sel; lra = p_sel;
          state_next = S_LINK2;
        end else begin
          // lrd: anchor links; anchor = lnk_a; new prior = p_sel
          lnk_b_next = p_sel;
          lwe = 1'b1; lwa = tgt; lwd = {lnk_a, p_sel};
          lra = p_sel;
          state_next = S_LINK2;
        end
        if (linkop == 2'd0) lwe = 1'b0;
      end
      S_LINK2: begin
        if (linkop == 2'd0) begin
          // rewrite prior.next = next
          lwe = 1'b1; lwa = lnk_a; lwd = {lnk_b, p_sel}; lra = lnk_b;
          state_next = S_LINK3;
        end else begin
          // p.next = x
          lwe = 1'b1; lwa = lnk_b; lwd = {tgt, (lnk_b == lnk_a) ? tgt : p_sel};
          lra = lnk_a;
          state_next = S_LINK3;
        end
      end
      S_LINK3: begin
        state_next = S_DONE;
        if (linkop == 2'd0) begin
          lwe = 1'b1; lwa = lnk_b; lwd = {n_sel, lnk_a};
          if (lnk_b == lnk_a) lwd = {lnk_b, lnk_a};
        end else begin
          // anchor.prior = x
          lwe = 1'b1; lwa = lnk_a;
          lwd = {(lnk_b == lnk_a) ? tgt : n_sel, tgt};
          if (linkop == 2'd2) oldest_next = tgt;
          else if (oldest == SENT) oldest_next = tgt;
        end
      end
      S_DONE: begin
        r_done = 1'b1; r_fr = tgt; state_next = S_IDLE;
        if (linkop == 2'd0 && lstep == 2'd3) begin
          fwe = 1'b1; fwd.valid = 1'b1; fwd.dirty = 1'b0; fwd.pins = PIN_BITS'(1);
          fwd.file = rfile; fwd.page = rpage;
          r_wb = tent.valid && tent.dirty; r_fill = (cmd == CMD_READ);
        end else if (linkop == 2'd0) begin
          fwe = 1'b1; fwd = tent; r_hit = 1'b1;
        end
      end
      S_FLUSH_RD: begin
        fra = idx; tgt_next = idx; state_next = S_FLUSH_CHK;
      end
      S_FLUSH_CHK: begin
        fra = idx; tent_next = fent; fwa = tgt;
        idx_next = IW'(idx + 1'b1);
        state_next = S_FLUSH_RD;
        if (fent.valid && fent.file == rfile) begin
          if (fent.pins != '0) begin
            r_done = 1'b1; r_st = ST_PINNED; r_fr = tgt; state_next = S_IDLE;
          end else begin
            fwe = 1'b1; fwd = fent; fwd.valid = 1'b0; fwd.dirty = 1'b0;
            if (fent.dirty) begin
              r_done = 1'b1; r_last = 1'b0; r_wb = 1'b1; r_fr = tgt;
            end
          end
        end
        if (state_next == S_FLUSH_RD && idx == IW'(NUM_FRAMES - 1)) state_next = S_DONE;
        if (state_next == S_DONE) linkop_next = 2'd1;
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_DONE && cmd == CMD_FLUSH) r_fr = '0;
  end

  `include "buffer_frame_manager_defines.svh"
  `BFM_ASSERT(a_busy_after_start, (start && !busy && command <= CMD_FLUSH) |=> busy, "start ignored")
  `BFM_ASSERT(a_done_only_busy, done |-> $past(busy), "result while idle")
  `BFM_ASSERT(a_oldest_range, oldest <= SENT, "oldest out of range")
  `BFM_ASSERT(a_idle_last, (done && !busy) |-> last, "idle without final result")
endmodule
`default_nettype wire

// File: dv/tb.sv
// testbench for the buffer frame manager: predictor scoreboard, directed and random requests
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfm_pkg::*;

  localparam int NF = 32;
  localparam int SENT = NF;
  localparam int PIN_MAX = 255;
  localparam int LIMIT = 20000;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] frame;
    logic hit;
    logic need_fill;
    logic writeback;
    logic [7:0] wb_file;
    logic [30:0] wb_page;
    logic last;
  } pool_result_t;

  int errors = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  class pool_scoreboard;
    bit valid_q[NF];
    bit dirty_q[NF];
    int pins[NF];
    logic [7:0] file_q[NF];
    logic [30:0] page_q[NF];
    int nxt[NF+1];
    int prv[NF+1];
    int oldest;
    pool_result_t pending[$];

    function new();
      for (int i = 0; i < NF; i++) begin
        valid_q[i] = 0; dirty_q[i] = 0; pins[i] = 0; file_q[i] = '0; page_q[i] = '0;
        nxt[i] = i + 1;
        prv[i] = (i == 0) ? SENT : i - 1;
      end
      nxt[SENT] = 0;
      prv[SENT] = SENT - 1;
      oldest = 0;
    endfunction

    function void push(int st, int fr, bit h, bit fl, bit wb, logic [7:0] wf,
                       logic [30:0] wp, bit lst);
      pool_result_t r;
      r.status = 3'(st); r.frame = 5'(fr); r.hit = h; r.need_fill = fl; r.writeback = wb;
      r.wb_file = wf; r.wb_page = wp; r.last = lst;
      pending.push_back(r);
    endfunction

    function int lookup(logic [7:0] f, logic [30:0] p);
      for (int i = 0; i < NF; i++)
        if (valid_q[i] && file_q[i] == f && page_q[i] == p) return i;
      return -1;
    endfunction

    function void detach(int x);
      int n, p;
      n = nxt[x]; p = prv[x];
      if (oldest == x) oldest = n;
      nxt[p] = n;
      prv[n] = p;
    endfunction

    function void join_front(int x);
      int p;
      p = prv[SENT];
      nxt[x] = SENT; prv[x] = p; nxt[p] = x; prv[SENT] = x;
      if (oldest == SENT) oldest = x;
    endfunction

    function void join_rear(int x);
      int r, p;
      r = oldest; p = prv[r];
      nxt[x] = r; prv[x] = p; nxt[p] = x; prv[r] = x;
      oldest = x;
    endfunction

    function void claim_victim(logic [7:0] f, logic [30:0] p, bit fill);
      int v;
      bit wb;
      v = oldest;
      if (v >= NF) begin
        push(ST_ALL_PINNED, 0, 0, 0, 0, 0, 0, 1);
        return;
      end
      detach(v);
      wb = valid_q[v] && dirty_q[v];
      push(ST_OK, v, 0, fill, wb, wb ? file_q[v] : 8'd0, wb ? page_q[v] : 31'd0, 1);
      valid_q[v] = 1; dirty_q[v] = 0; pins[v] = 1; file_q[v] = f; page_q[v] = p;
    endfunction

    function void note_request(logic [2:0] c, logic [7:0] f, logic [30:0] p, bit d, bit k);
      int h, x;
      h = lookup(f, p);
      x = (h < 0) ? 0 : h;
      case (c)
        CMD_READ: begin
          if (h < 0) claim_victim(f, p, 1);
          else if (pins[x] >= PIN_MAX) push(ST_PIN_LIMIT, x, 1, 0, 0, 0, 0, 1);
          else begin
            if (pins[x] == 0) detach(x);
            pins[x]++;
            push(ST_OK, x, 1, 0, 0, 0, 0, 1);
          end
        end
        CMD_ALLOC: begin
          if (h >= 0) push(ST_BAD_FRAME, x, 0, 0, 0, 0, 0, 1);
          else claim_victim(f, p, 0);
        end
        CMD_UNPIN: begin
          if (h < 0) push(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0, 1);
          else if (pins[x] == 0) push(ST_NOT_PINNED, x, 0, 0, 0, 0, 0, 1);
          else begin
            if (d) dirty_q[x] = 1;
            pins[x]--;
            if (pins[x] == 0) begin
              if (k) join_front(x);
              else join_rear(x);
            end
            push(ST_OK, x, 0, 0, 0, 0, 0, 1);
          end
        end
        CMD_DISPOSE: begin
          if (h < 0) push(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0, 1);
          else if (pins[x] > 0) push(ST_PINNED, x, 0, 0, 0, 0, 0, 1);
          else begin
            valid_q[x] = 0; dirty_q[x] = 0;
            push(ST_OK, x, 0, 0, 0, 0, 0, 1);
          end
        end
        CMD_FLUSH: begin
          for (int i = 0; i < NF; i++) begin
            if (!valid_q[i] || file_q[i] != f) continue;
            if (pins[i] > 0) begin
              push(ST_PINNED, i, 0, 0, 0, 0, 0, 1);
              return;
            end
            if (dirty_q[i]) begin
              push(ST_OK, i, 0, 0, 1, file_q[i], page_q[i], 0);
              dirty_q[i] = 0;
            end
            valid_q[i] = 0;
          end
          push(ST_OK, 0, 0, 0, 0, 0, 0, 1);
        end
        default: ;
      endcase
    endfunction

    task check_result(input pool_result_t got);
      pool_result_t exp;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.frame !== exp.frame)
        report($sformatf("frame %0d, expected %0d", got.frame, exp.frame));
      if (got.hit !== exp.hit) report($sformatf("hit %0b, expected %0b", got.hit, exp.hit));
      if (got.need_fill !== exp.need_fill)
        report($sformatf("need_fill %0b, expected %0b", got.need_fill, exp.need_fill));
      if (got.writeback !== exp.writeback)
        report($sformatf("writeback %0b, expected %0b", got.writeback, exp.writeback));
      if (got.wb_file !== exp.wb_file)
        report($sformatf("writeback_file %0h, expected %0h", got.wb_file, exp.wb_file));
      if (got.wb_page !== exp.wb_page)
        report($sformatf("writeback_page %0h, expected %0h", got.wb_page, exp.wb_page));
      if (got.last !== exp.last)
        report($sformatf("last %0b, expected %0b", got.last, exp.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [2:0] command = '0;
  logic [7:0] file_id = '0;
  logic [30:0] page_number = '0;
  logic dirty = 0;
  logic keep_recent = 0;
  logic done;
  logic [2:0] status;
  logic [4:0] frame;
  logic hit, need_fill, writeback, last;
  logic [7:0] writeback_file;
  logic [30:0] writeback_page;

  buffer_frame_manager u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .file_id(file_id), .page_number(page_number), .dirty(dirty),
    .keep_recent(keep_recent), .done(done), .status(status), .frame(frame), .hit(hit),
    .need_fill(need_fill), .writeback(writeback), .writeback_file(writeback_file),
    .writeback_page(writeback_page), .last(last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pool_scoreboard sb = new();
  int idle_pct = 0;
  int quiet = 0;
  logic [30:0] pages_in_use[8];
  logic [7:0] files_in_use[4];

  always @(posedge clk) begin
    pool_result_t r;
    if (!rst) begin
      if (done) begin
        r.status = status; r.frame = frame; r.hit = hit; r.need_fill = need_fill;
        r.writeback = writeback; r.wb_file = writeback_file; r.wb_page = writeback_page;
        r.last = last;
        sb.check_result(r);
      end
      if (done || (start && !busy)) quiet = 0;
      else quiet++;
      if (quiet >= LIMIT) begin
        $display("buffer_frame_manager test failed");
        $finish;
      end
    end
  end

  // one request; sender gaps drawn before raising start
  task automatic send(input logic [2:0] c, input logic [7:0] f, input logic [30:0] p,
                      input bit d, input bit k);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1; command <= c; file_id <= f; page_number <= p; dirty <= d;
    keep_recent <= k;
    do @(posedge clk); while (busy);
    sb.note_request(c, f, p, d, k);
    start <= 0;
    @(posedge clk);
  endtask

  task automatic send_random();
    int sel;
    logic [2:0] c;
    sel = $urandom_range(99);
    if (sel < 3) c = 3'd5 + 3'($urandom_range(2));
    else if (sel < 35) c = CMD_READ;
    else if (sel < 50) c = CMD_ALLOC;
    else if (sel < 82) c = CMD_UNPIN;
    else if (sel < 92) c = CMD_DISPOSE;
    else c = CMD_FLUSH;
    if ($urandom_range(9) == 0)
      send(c, 8'($urandom), 31'($urandom), 1'($urandom), 1'($urandom));
    else
      send(c, files_in_use[$urandom_range(3)], pages_in_use[$urandom_range(7)],
           1'($urandom), 1'($urandom));
  endtask

  initial begin
    int wait_n;
    for (int i = 0; i < 8; i++) pages_in_use[i] = 31'($urandom);
    pages_in_use[0] = 31'h7fffffff;
    pages_in_use[1] = 0;
    files_in_use = '{8'hff, 8'h00, 8'($urandom), 8'($urandom)};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, each command, error paths
    send(CMD_UNPIN, 8'hff, 31'h7fffffff, 1, 1);
    send(CMD_DISPOSE, 8'h00, 31'h0, 0, 0);
    send(CMD_READ, 8'hff, 31'h7fffffff, 0, 0);
    send(CMD_READ, 8'hff, 31'h7fffffff, 0, 0);
    send(CMD_ALLOC, 8'hff, 31'h7fffffff, 0, 0);
    send(CMD_ALLOC, 8'h00, 31'h0, 0, 0);
    send(CMD_DISPOSE, 8'h00, 31'h0, 0, 0);
    send(CMD_UNPIN, 8'h00, 31'h0, 1, 0);
    send(CMD_UNPIN, 8'h00, 31'h0, 1, 0);
    send(CMD_UNPIN, 8'hff, 31'h7fffffff, 1, 1);
    send(CMD_FLUSH, 8'hff, 31'h0, 0, 0);
    send(CMD_UNPIN, 8'hff, 31'h7fffffff, 0, 1);
    send(CMD_FLUSH, 8'hff, 31'h0, 0, 0);
    send(CMD_DISPOSE, 8'h00, 31'h0, 0, 0);
    send(3'd7, 8'h55, 31'h2aaaaaaa, 1, 1);
    // fill every frame, then one more read finds all pinned
    for (int i = 0; i < NF; i++) send(CMD_READ, 8'h11, 31'(i), 0, 0);
    send(CMD_READ, 8'h22, 31'h5, 0, 0);
    for (int i = 0; i < NF; i++) send(CMD_UNPIN, 8'h11, 31'(i), i[0], i[1]);
    send(CMD_FLUSH, 8'h11, 31'h0, 0, 0);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 51 : (ph == 3 ? 31 : 0);
      repeat (6) send_random();
    end
    for (int i = 0; i < 4; i++) send(CMD_FLUSH, files_in_use[i], 31'h0, 0, 0);
    wait_n = 0;
    while (sb.pending.size() != 0 && wait_n < LIMIT) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (2 * NF + 10) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) $display("buffer_frame_manager test passed");
    else $display("buffer_frame_manager test failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
+incdir+design
design/bfm_pkg.sv
design/buffer_frame_manager.sv
dv/tb.sv
